// ===== rtl/epll_pkg.sv =====
// Shared types and constants of the encoder phase PLL tracker.
// Holds the microcode word, its field codes and the control store.
// No dependencies.
package epll_pkg;

    // Fixed-point constants, Q.16 radians
    localparam logic [18:0] PHASE_PI_Q16  = 19'd205887;
    localparam logic [18:0] PHASE_2PI_Q16 = 19'd411775;

    // Product of the shared multiplier: signed 33 x unsigned 32
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Velocity increment clamp, +/- 2^48
    localparam logic signed [PROD_W-1:0] DV_MAX = 65'sh1_0000_0000_0000;
    localparam logic signed [PROD_W-1:0] DV_MIN = -DV_MAX;

    // Remainder unit: magnitude dividend, divisor below 2^19
    localparam int DIVD_W     = 36;
    localparam int REM_W      = 20;
    localparam int RADIX_BITS = 4;
    localparam int DIV_ITERS  = DIVD_W / RADIX_BITS;
    localparam int ITER_W     = $clog2(DIV_ITERS);

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_OFFSET  = 3'd0,
        CFG_REVERSE = 3'd1,
        CFG_ERPC    = 3'd2,
        CFG_PGD     = 3'd3,
        CFG_VGD     = 3'd4,
        CFG_PERIOD  = 3'd5
    } cfg_reg_t;

    // Microcode fields
    typedef enum logic [1:0] {
        MA_VLO  = 2'd0,
        MA_VHI  = 2'd1,
        MA_ERR  = 2'd2,
        MA_CORR = 2'd3
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_SP   = 2'd0,
        MB_PGD  = 2'd1,
        MB_VGD  = 2'd2,
        MB_ERPC = 2'd3
    } mul_b_sel_t;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_TAKE  = 4'd1,
        OP_LH    = 4'd2,
        OP_XSUM  = 4'd3,
        OP_PRED  = 4'd4,
        OP_ERR   = 4'd5,
        OP_PCORR = 4'd6,
        OP_DV    = 4'd7,
        OP_VEL   = 4'd8,
        OP_CORR  = 4'd9,
        OP_PHY   = 4'd10,
        OP_OUT   = 4'd11
    } dp_op_t;

    typedef enum logic {
        RS_COUNT = 1'b0,
        RS_PHASE = 1'b1
    } rem_sel_t;

    typedef enum logic [1:0] {
        H_NONE = 2'd0,
        H_IN   = 2'd1,
        H_REM  = 2'd2,
        H_OUT  = 2'd3
    } hold_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE = 4'd0;
    localparam step_t ST_MVL  = 4'd1;
    localparam step_t ST_MVH  = 4'd2;
    localparam step_t ST_XSUM = 4'd3;
    localparam step_t ST_PRED = 4'd4;
    localparam step_t ST_ERR  = 4'd5;
    localparam step_t ST_MPG  = 4'd6;
    localparam step_t ST_MVG  = 4'd7;
    localparam step_t ST_DV   = 4'd8;
    localparam step_t ST_VEL  = 4'd9;
    localparam step_t ST_CORR = 4'd10;
    localparam step_t ST_MPH  = 4'd11;
    localparam step_t ST_PHY  = 4'd12;
    localparam step_t ST_RPH  = 4'd13;
    localparam step_t ST_OUT  = 4'd14;

    typedef struct packed {
        hold_t      hold;
        logic       jump;
        step_t      target;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        logic       mul_en;
        logic       rem_start;
        rem_sel_t   rem_sel;
        dp_op_t     op;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic rem_busy;
        logic out_full;
    } seq_cond_t;

    localparam ucode_t UC_NOP = '{
        hold: H_NONE, jump: 1'b0, target: ST_IDLE, mul_a: MA_VLO, mul_b: MB_SP,
        mul_en: 1'b0, rem_start: 1'b0, rem_sel: RS_COUNT, op: OP_NONE
    };

    // Control store
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t uc;
        uc = UC_NOP;
        case (pc)
            ST_IDLE:
            begin
                uc.hold = H_IN;
                uc.op   = OP_TAKE;
            end
            ST_MVL:
            begin
                uc.mul_a     = MA_VLO;
                uc.mul_b     = MB_SP;
                uc.mul_en    = 1'b1;
                uc.rem_start = 1'b1;
                uc.rem_sel   = RS_COUNT;
            end
            ST_MVH:
            begin
                uc.mul_a  = MA_VHI;
                uc.mul_b  = MB_SP;
                uc.mul_en = 1'b1;
                uc.op     = OP_LH;
            end
            ST_XSUM: uc.op = OP_XSUM;
            ST_PRED: uc.op = OP_PRED;
            ST_ERR:  uc.op = OP_ERR;
            ST_MPG:
            begin
                uc.mul_a  = MA_ERR;
                uc.mul_b  = MB_PGD;
                uc.mul_en = 1'b1;
            end
            ST_MVG:
            begin
                uc.mul_a  = MA_ERR;
                uc.mul_b  = MB_VGD;
                uc.mul_en = 1'b1;
                uc.op     = OP_PCORR;
            end
            ST_DV:   uc.op = OP_DV;
            ST_VEL:  uc.op = OP_VEL;
            ST_CORR:
            begin
                uc.hold = H_REM;
                uc.op   = OP_CORR;
            end
            ST_MPH:
            begin
                uc.mul_a  = MA_CORR;
                uc.mul_b  = MB_ERPC;
                uc.mul_en = 1'b1;
            end
            ST_PHY:  uc.op = OP_PHY;
            ST_RPH:
            begin
                uc.rem_start = 1'b1;
                uc.rem_sel   = RS_PHASE;
            end
            ST_OUT:
            begin
                uc.hold   = H_OUT;
                uc.op     = OP_OUT;
                uc.jump   = 1'b1;
                uc.target = ST_IDLE;
            end
            default:
            begin
                uc.jump   = 1'b1;
                uc.target = ST_IDLE;
            end
        endcase
        return uc;
    endfunction

endpackage

// ===== rtl/encoder_phase_pll_tracker_unit.sv =====
// Top level of the encoder phase PLL tracker: streams, config, datapath.
// Depends on epll_pkg, epll_seq, epll_mul and epll_rem.
//
// Takes one raw 16-bit encoder counter sample per transaction on the slave
// stream and returns one transaction on the master stream carrying the
// electrical phase (signed Q3.16 rad, wrapped to +/- pi), the floored PLL
// position in counts and the PLL velocity (signed Q32.16 counts/s). Work is
// run by a 15-step microprogram over one shared 33x32 multiplier and one
// remainder unit that retires four bits a cycle while busy. Each item goes
// through two remainder passes (count modulo counts-per-rev, phase modulo
// 2*pi) and the multiply/add steps of the PLL, the count pass running
// alongside the PLL steps. The result sits in an output register, so the next
// sample is accepted while it waits; the sequencer stalls for an untaken
// previous result only at its last step, which also waits on the phase pass.
// Configuration writes are accepted at any time (cfg_ready is always high) but
// are meant to be done while idle. No clearing pass is needed after reset.
module encoder_phase_pll_tracker_unit
#(
    parameter int COUNTS_PER_REV = 8192
)
(
    input  logic         clk,
    input  logic         rst_n,
    // slave stream: [15:0] counter_value
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,
    // master stream: [18:0] electrical_phase, [50:19] position_estimate,
    // [98:51] velocity_estimate, [103:99] zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [31:0] ERPC_RST   = 32'd23058430;
    localparam logic [23:0] PGD_RST    = 24'd4194304;
    localparam logic [31:0] VGD_RST    = 32'd8192000;
    localparam logic [31:0] PERIOD_RST = 32'd536871;

    // configuration
    logic [15:0] offset_reg;
    logic        reverse_reg;
    logic [31:0] erpc_reg;
    logic [23:0] pgd_reg;
    logic [31:0] vgd_reg;
    logic [31:0] period_reg;

    // tracker state
    logic [31:0]        rc_reg;
    logic [31:0]        rc_next;
    logic signed [47:0] pos_reg;
    logic signed [47:0] pos_next;
    logic signed [47:0] vel_reg;
    logic signed [47:0] vel_next;

    // scratch registers
    logic [31:0]        lh_reg;
    logic signed [56:0] acc_reg;
    logic [31:0]        err_reg;
    logic signed [49:0] dv_reg;
    logic signed [17:0] corr_reg;

    // result buffer
    logic        out_valid_reg;
    logic [18:0] out_phase_reg;
    logic [31:0] out_pos_reg;
    logic [47:0] out_vel_reg;

    // sequencer and shared units
    epll_pkg::ucode_t    ctrl;
    epll_pkg::seq_cond_t cond;
    logic                fire;
    logic                idle;
    logic                out_full;

    logic signed [epll_pkg::MUL_A_W-1:0] mul_a;
    logic        [epll_pkg::MUL_B_W-1:0] mul_b;
    logic signed [epll_pkg::PROD_W-1:0]  prod;

    logic [epll_pkg::DIVD_W-1:0] rem_dividend;
    logic [epll_pkg::REM_W-1:0]  rem_divisor;
    logic                        rem_busy;
    logic [epll_pkg::REM_W-1:0]  rem_out;

    // datapath candidates
    logic [15:0]        delta;
    logic [31:0]        rc_take;
    logic signed [56:0] xsum;
    logic [31:0]        err_calc;
    logic signed [49:0] dv_calc;
    logic signed [49:0] vel_sum;
    logic signed [47:0] vel_sat;
    logic [16:0]        cnt_rem;
    logic [17:0]        cnt_mod;
    logic [17:0]        corr_a;
    logic [17:0]        corr_calc;
    logic [34:0]        ph;
    logic [35:0]        ph_shift;
    logic [31:0]        rc_mag;
    logic [35:0]        y_mag;
    logic [18:0]        ph_rem;
    logic [18:0]        ph_wrap;
    logic [18:0]        phase_calc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            reverse_reg <= 1'b0;
            erpc_reg    <= ERPC_RST;
            pgd_reg     <= PGD_RST;
            vgd_reg     <= VGD_RST;
            period_reg  <= PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                epll_pkg::CFG_OFFSET:  offset_reg  <= cfg_data[15:0];
                epll_pkg::CFG_REVERSE: reverse_reg <= cfg_data[0];
                epll_pkg::CFG_ERPC:    erpc_reg    <= cfg_data;
                epll_pkg::CFG_PGD:     pgd_reg     <= cfg_data[23:0];
                epll_pkg::CFG_VGD:     vgd_reg     <= cfg_data;
                epll_pkg::CFG_PERIOD:  period_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // sequencer
    assign out_full      = out_valid_reg && !m_axis_tready;
    assign cond.in_valid = s_axis_tvalid;
    assign cond.rem_busy = rem_busy;
    assign cond.out_full = out_full;

    epll_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl),
        .fire  (fire),
        .idle  (idle)
    );

    assign s_axis_tready = idle;

    // multiplier operands; velocity is split into 24-bit halves
    always_comb
    begin
        case (ctrl.mul_a)
            epll_pkg::MA_VLO:  mul_a = {9'b0, vel_reg[23:0]};
            epll_pkg::MA_VHI:  mul_a = {{9{vel_reg[47]}}, vel_reg[47:24]};
            epll_pkg::MA_ERR:  mul_a = {err_reg[31], err_reg};
            epll_pkg::MA_CORR: mul_a = {{15{corr_reg[17]}}, corr_reg};
            default:           mul_a = '0;
        endcase
        case (ctrl.mul_b)
            epll_pkg::MB_SP:   mul_b = period_reg;
            epll_pkg::MB_PGD:  mul_b = {8'b0, pgd_reg};
            epll_pkg::MB_VGD:  mul_b = vgd_reg;
            epll_pkg::MB_ERPC: mul_b = erpc_reg;
            default:           mul_b = '0;
        endcase
    end

    epll_mul u_mul
    (
        .clk  (clk),
        .en   (fire && ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // remainder operands: magnitudes, sign handled around the unit
    assign rc_mag = rc_reg[31] ? -rc_reg : rc_reg;
    assign y_mag  = acc_reg[35] ? -acc_reg[35:0] : acc_reg[35:0];

    always_comb
    begin
        case (ctrl.rem_sel)
            epll_pkg::RS_COUNT:
            begin
                rem_dividend = {4'b0, rc_mag};
                rem_divisor  = epll_pkg::REM_W'(COUNTS_PER_REV);
            end
            epll_pkg::RS_PHASE:
            begin
                rem_dividend = y_mag;
                rem_divisor  = {1'b0, epll_pkg::PHASE_2PI_Q16};
            end
            default:
            begin
                rem_dividend = '0;
                rem_divisor  = '0;
            end
        endcase
    end

    epll_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fire && ctrl.rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .busy     (rem_busy),
        .rem      (rem_out)
    );

    // count extension by the signed 16-bit step
    assign delta   = s_axis_tdata - rc_reg[15:0];
    assign rc_take = rc_reg + {{16{delta[15]}}, delta};

    // predict: floor(v*dt/2^32) = floor((vh*dt + (vl*dt >> 24)) / 2^8)
    assign xsum     = prod[56:0] + $signed({25'b0, lh_reg});
    assign err_calc = rc_reg - pos_reg[47:16];

    // velocity increment clamped to +/- 2^48, then saturated sum
    always_comb
    begin
        if (prod > epll_pkg::DV_MAX)
        begin
            dv_calc = epll_pkg::DV_MAX[49:0];
        end
        else if (prod < epll_pkg::DV_MIN)
        begin
            dv_calc = epll_pkg::DV_MIN[49:0];
        end
        else
        begin
            dv_calc = prod[49:0];
        end
    end

    assign vel_sum = {{2{vel_reg[47]}}, vel_reg} + dv_reg;

    always_comb
    begin
        if (!vel_sum[49] && (vel_sum[48:47] != 2'b00))
        begin
            vel_sat = {1'b0, {47{1'b1}}};
        end
        else if (vel_sum[49] && (vel_sum[48:47] != 2'b11))
        begin
            vel_sat = {1'b1, {47{1'b0}}};
        end
        else
        begin
            vel_sat = vel_sum[47:0];
        end
    end

    // count modulo counts-per-rev keeps the sign of the count
    assign cnt_rem   = rem_out[16:0];
    assign cnt_mod   = rc_reg[31] ? -{1'b0, cnt_rem} : {1'b0, cnt_rem};
    assign corr_a    = cnt_mod - {{2{offset_reg[15]}}, offset_reg};
    assign corr_calc = reverse_reg ? -corr_a : corr_a;

    // scaled phase shifted by pi ahead of the 2*pi reduction
    assign ph       = prod[50:16];
    assign ph_shift = {ph[34], ph} + {17'b0, epll_pkg::PHASE_PI_Q16};

    // floored modulo 2*pi, then back to +/- pi
    assign ph_rem     = rem_out[18:0];
    assign ph_wrap    = (acc_reg[35] && (ph_rem != '0))
                      ? epll_pkg::PHASE_2PI_Q16 - ph_rem : ph_rem;
    assign phase_calc = ph_wrap - epll_pkg::PHASE_PI_Q16;

    // state updates
    always_comb
    begin
        rc_next  = rc_reg;
        pos_next = pos_reg;
        vel_next = vel_reg;
        if (fire)
        begin
            case (ctrl.op)
                epll_pkg::OP_TAKE:  rc_next  = rc_take;
                epll_pkg::OP_PRED:  pos_next = pos_reg + acc_reg[55:8];
                epll_pkg::OP_PCORR: pos_next = pos_reg + prod[55:8];
                epll_pkg::OP_VEL:   vel_next = vel_sat;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg  <= '0;
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else
        begin
            rc_reg  <= rc_next;
            pos_reg <= pos_next;
            vel_reg <= vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (ctrl.op)
                epll_pkg::OP_LH:   lh_reg   <= prod[55:24];
                epll_pkg::OP_XSUM: acc_reg  <= xsum;
                epll_pkg::OP_ERR:  err_reg  <= err_calc;
                epll_pkg::OP_DV:   dv_reg   <= dv_calc;
                epll_pkg::OP_CORR: corr_reg <= corr_calc;
                epll_pkg::OP_PHY:  acc_reg  <= {{21{ph_shift[35]}}, ph_shift};
                epll_pkg::OP_OUT:
                begin
                    out_phase_reg <= phase_calc;
                    out_pos_reg   <= pos_reg[47:16];
                    out_vel_reg   <= vel_reg;
                end
                default: ;
            endcase
        end
    end

    // output register: loaded at the last step, freed by the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && (ctrl.op == epll_pkg::OP_OUT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_vel_reg, out_pos_reg, out_phase_reg};

endmodule

// ===== rtl/epll_mul.sv =====
// Shared registered multiplier: signed 33-bit by unsigned 32-bit.
// Depends on epll_pkg for operand widths.
module epll_mul
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [epll_pkg::MUL_A_W-1:0] a,
    input  logic        [epll_pkg::MUL_B_W-1:0] b,
    output logic signed [epll_pkg::PROD_W-1:0]  prod
);

    logic signed [epll_pkg::PROD_W-1:0] prod_reg;
    logic signed [epll_pkg::PROD_W-1:0] prod_next;

    assign prod_next = epll_pkg::PROD_W'(a * $signed({1'b0, b}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/epll_rem.sv =====
// Restoring remainder unit, four quotient bits per cycle.
// Depends on epll_pkg for widths and iteration count.
module epll_rem
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [epll_pkg::DIVD_W-1:0]       dividend,
    input  logic [epll_pkg::REM_W-1:0]        divisor,
    output logic                              busy,
    output logic [epll_pkg::REM_W-1:0]        rem
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [epll_pkg::ITER_W-1:0]    cnt_reg;
    logic [epll_pkg::ITER_W-1:0]    cnt_next;
    logic [epll_pkg::DIVD_W-1:0]    shift_reg;
    logic [epll_pkg::REM_W-1:0]     rem_reg;
    logic [epll_pkg::REM_W-1:0]     rem_next;
    logic [epll_pkg::REM_W-1:0]     divisor_reg;

    // four compare/subtract steps on the partial remainder
    always_comb
    begin
        logic [epll_pkg::REM_W-1:0] t;
        logic [epll_pkg::REM_W-1:0] tt;
        t  = rem_reg;
        tt = '0;
        for (int i = 0; i < epll_pkg::RADIX_BITS; i++)
        begin
            tt = {t[epll_pkg::REM_W-2:0], shift_reg[epll_pkg::DIVD_W-1-i]};
            t  = (tt >= divisor_reg) ? tt - divisor_reg : tt;
        end
        rem_next = t;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == epll_pkg::ITER_W'(epll_pkg::DIV_ITERS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << epll_pkg::RADIX_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/epll_seq.sv =====
// Microcode sequencer: step counter, control store lookup, hold and jump.
// Depends on epll_pkg for the control word and the control store.
module epll_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  epll_pkg::seq_cond_t  cond,
    output epll_pkg::ucode_t     ctrl,
    output logic                 fire,
    output logic                 idle
);

    epll_pkg::step_t pc_reg;
    epll_pkg::step_t pc_next;
    logic            hold_active;

    assign ctrl = epll_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.hold)
            epll_pkg::H_NONE: hold_active = 1'b0;
            epll_pkg::H_IN:   hold_active = !cond.in_valid;
            epll_pkg::H_REM:  hold_active = cond.rem_busy;
            epll_pkg::H_OUT:  hold_active = cond.rem_busy || cond.out_full;
            default:          hold_active = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold_active)
        begin
            pc_next = pc_reg;
        end
        else if (ctrl.jump)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= epll_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign fire = !hold_active;
    assign idle = (pc_reg == epll_pkg::ST_IDLE);

endmodule

// ===== rtl/epll_chk.sv =====
// Port-level checker for the encoder phase PLL tracker, and its bind.
// Depends on encoder_phase_pll_tracker_unit only through its ports.
module epll_chk
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    // one sample at a time: input closes after each transaction
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still open after a transaction");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result presented while an item is in flight");

    // phase stays within +/- pi
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[18:0]) >= -20'sd205887)
                       && ($signed(m_axis_tdata[18:0]) <= 20'sd205887)
                       && (m_axis_tdata[103:99] == 5'b0))
        else $error("phase out of range or padding set");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind encoder_phase_pll_tracker_unit epll_chk u_epll_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
